// ===== src/bsle_pkg.sv =====
// bsle_pkg: shared widths, request and status codes, datapath command and status types
// used by the interfaces, the controller, the datapath and the top level
`timescale 1ns / 1ps

package bsle_pkg;

  localparam int DEPTH       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int DATA_W      = 32;
  localparam int REQ_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 5;
  localparam int IDX_W       = $clog2(DEPTH + 1);
  localparam int ADDR_W      = $clog2(DEPTH);

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_SORT       = 3'd4,
    REQ_INSERT     = 3'd5,
    REQ_REMOVE     = 3'd6,
    REQ_LIST       = 3'd7
  } req_code_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    A_IDX    = 3'd0,
    A_IDX_M1 = 3'd1,
    A_IDX_P1 = 3'd2,
    A_OCC    = 3'd3,
    A_OCC_M1 = 3'd4,
    A_POS    = 3'd5
  } addr_sel_t;

  typedef enum logic [1:0] {
    W_OPND  = 2'd0,
    W_RDATA = 2'd1,
    W_CARRY = 2'd2
  } wdata_sel_t;

  typedef enum logic [2:0] {
    I_HOLD = 3'd0,
    I_INC  = 3'd1,
    I_DEC  = 3'd2,
    I_ZERO = 3'd3,
    I_OCC  = 3'd4
  } idx_op_t;

  typedef enum logic [1:0] {
    P_HOLD   = 2'd0,
    P_IDX    = 2'd1,
    P_OCC_M1 = 2'd2,
    P_DEC    = 2'd3
  } pos_op_t;

  typedef enum logic [1:0] {
    O_HOLD = 2'd0,
    O_INC  = 2'd1,
    O_DEC  = 2'd2
  } occ_op_t;

  typedef struct packed {
    logic       load;
    logic       rd;
    logic       wr;
    addr_sel_t  addr_sel;
    wdata_sel_t wdata_sel;
    idx_op_t    idx_op;
    pos_op_t    pos_op;
    occ_op_t    occ_op;
    logic       val_capture;
    logic       carry_capture;
    logic       swap_clr;
    logic       swap_set;
    logic       res_en;
    status_t    res_status;
    logic       res_last;
    logic       res_rdata;
  } dp_cmd_t;

  typedef struct packed {
    req_code_t req;
    logic      occ_zero;
    logic      occ_full;
    logic      occ_one;
    logic      idx_eq_occ;
    logic      idx_eq_pos;
    logic      idx_p1_eq_occ;
    logic      idx_last;
    logic      pos_one;
    logic      lt_opnd;
    logic      eq_opnd;
    logic      lt_carry;
    logic      swap;
    logic      out_fire;
    logic      out_last;
  } dp_sts_t;

endpackage

// ===== src/bsle_in_if.sv =====
// bsle_in_if: request channel, valid/ready with request code and operand
// depends on bsle_pkg
`timescale 1ns / 1ps

interface bsle_in_if import bsle_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [DATA_W-1:0] operand_value;

  modport source (output valid, output req_type, output operand_value, input ready);
  modport sink   (input valid, input req_type, input operand_value, output ready);
endinterface

// ===== src/bsle_out_if.sv =====
// bsle_out_if: result channel, valid/ready with entry value, status, count and last flag
// depends on bsle_pkg
`timescale 1ns / 1ps

interface bsle_out_if import bsle_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] entry_value;
  logic [STATUS_W-1:0]      status;
  logic [COUNT_W-1:0]       entry_count;
  logic                     last_of_run;

  modport source (output valid, output entry_value, output status, output entry_count,
                  output last_of_run, input ready);
  modport sink   (input valid, input entry_value, input status, input entry_count,
                  input last_of_run, output ready);
endinterface

// ===== src/bsle_datapath.sv =====
// bsle_datapath: entry memory, occupancy, walk indices, sort carry and result register
// depends on bsle_pkg and bsle_out_if; driven by commands from bsle_ctrl
`timescale 1ns / 1ps

module bsle_datapath import bsle_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  cmd,
  input  logic [REQ_W-1:0]         in_req_type,
  input  logic signed [DATA_W-1:0] in_operand_value,
  output dp_sts_t                  sts,
  bsle_out_if.source               out_res
);

  logic [DATA_W-1:0]        mem [DEPTH];
  logic signed [DATA_W-1:0] rdata_r;
  logic signed [DATA_W-1:0] opnd_r;
  logic signed [DATA_W-1:0] carry_r;
  logic signed [DATA_W-1:0] val_r;
  req_code_t                req_r;
  logic [IDX_W-1:0]         occ_r, occ_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [IDX_W-1:0]         pos_r, pos_nxt;
  logic                     swap_r;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_value_r;
  status_t                  out_status_r;
  logic [COUNT_W-1:0]       out_count_r;
  logic                     out_last_r;

  logic [IDX_W-1:0]         addr_w;
  logic [ADDR_W-1:0]        addr;
  logic [DATA_W-1:0]        wdata;
  logic [IDX_W-1:0]         idx_p1;
  logic                     out_fire;

  assign idx_p1   = idx_r + IDX_W'(1);
  assign out_fire = out_valid_r && out_res.ready;

  always_comb begin
    case (cmd.addr_sel)
      A_IDX:    addr_w = idx_r;
      A_IDX_M1: addr_w = idx_r - IDX_W'(1);
      A_IDX_P1: addr_w = idx_p1;
      A_OCC:    addr_w = occ_r;
      A_OCC_M1: addr_w = occ_r - IDX_W'(1);
      A_POS:    addr_w = pos_r;
      default:  addr_w = idx_r;
    endcase
  end
  assign addr = addr_w[ADDR_W-1:0];

  always_comb begin
    case (cmd.wdata_sel)
      W_OPND:  wdata = opnd_r;
      W_RDATA: wdata = rdata_r;
      W_CARRY: wdata = carry_r;
      default: wdata = opnd_r;
    endcase
  end

  // single port entry store with registered read
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd) begin
      rdata_r <= mem[addr];
    end
  end

  always_comb begin
    case (cmd.idx_op)
      I_INC:   idx_nxt = idx_p1;
      I_DEC:   idx_nxt = idx_r - IDX_W'(1);
      I_ZERO:  idx_nxt = '0;
      I_OCC:   idx_nxt = occ_r;
      default: idx_nxt = idx_r;
    endcase
    if (cmd.load) begin
      idx_nxt = '0;
    end
  end

  always_comb begin
    case (cmd.pos_op)
      P_IDX:    pos_nxt = idx_r;
      P_OCC_M1: pos_nxt = occ_r - IDX_W'(1);
      P_DEC:    pos_nxt = pos_r - IDX_W'(1);
      default:  pos_nxt = pos_r;
    endcase
  end

  always_comb begin
    case (cmd.occ_op)
      O_INC:   occ_nxt = occ_r + IDX_W'(1);
      O_DEC:   occ_nxt = occ_r - IDX_W'(1);
      default: occ_nxt = occ_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      if (cmd.res_en) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    pos_r <= pos_nxt;
    if (cmd.load) begin
      req_r  <= req_code_t'(in_req_type);
      opnd_r <= in_operand_value;
      val_r  <= '0;
    end else if (cmd.val_capture) begin
      val_r <= rdata_r;
    end
    if (cmd.carry_capture) begin
      carry_r <= rdata_r;
    end
    if (cmd.swap_clr) begin
      swap_r <= 1'b0;
    end else if (cmd.swap_set) begin
      swap_r <= 1'b1;
    end
    if (cmd.res_en) begin
      out_value_r  <= cmd.res_rdata ? rdata_r : val_r;
      out_status_r <= cmd.res_status;
      out_count_r  <= COUNT_W'(occ_r);
      out_last_r   <= cmd.res_last;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.entry_value = out_value_r;
  assign out_res.status      = out_status_r;
  assign out_res.entry_count = out_count_r;
  assign out_res.last_of_run = out_last_r;

  always_comb begin
    sts.req           = req_r;
    sts.occ_zero      = (occ_r == '0);
    sts.occ_full      = (occ_r == IDX_W'(DEPTH));
    sts.occ_one       = (occ_r == IDX_W'(1));
    sts.idx_eq_occ    = (idx_r == occ_r);
    sts.idx_eq_pos    = (idx_r == pos_r);
    sts.idx_p1_eq_occ = (idx_p1 == occ_r);
    // a listing stops at the end of the list or at the result limit
    sts.idx_last      = (idx_p1 == occ_r) || (idx_p1 == IDX_W'(MAX_RESULTS));
    sts.pos_one       = (pos_r == IDX_W'(1));
    sts.lt_opnd       = (opnd_r < rdata_r);
    sts.eq_opnd       = (opnd_r == rdata_r);
    sts.lt_carry      = (rdata_r < carry_r);
    sts.swap          = swap_r;
    sts.out_fire      = out_fire;
    sts.out_last      = out_last_r;
  end

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> (addr_w < IDX_W'(DEPTH)))
    else $error("entry write outside the list storage");

  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |-> (addr_w < occ_r))
    else $error("entry read beyond the occupied part of the list");

  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (occ_r == $past(occ_r) || occ_r == $past(occ_r) + IDX_W'(1) ||
              occ_r == $past(occ_r) - IDX_W'(1)))
    else $error("occupancy moved by more than one");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_nxt != occ_r) |=> (occ_r <= IDX_W'(DEPTH)))
    else $error("occupancy beyond depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_en |-> !out_valid_r)
    else $error("new result while previous one still pending");

endmodule

// ===== src/bsle_ctrl.sv =====
// bsle_ctrl: request sequencer for the list engine, issues one datapath command per cycle
// depends on bsle_pkg; status comes back from bsle_datapath
`timescale 1ns / 1ps

module bsle_ctrl import bsle_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [20:0] {
    S_IDLE      = 21'h000001,
    S_DISPATCH  = 21'h000002,
    S_UP        = 21'h000004,
    S_UP_WR     = 21'h000008,
    S_DN        = 21'h000010,
    S_DN_WR     = 21'h000020,
    S_POPF      = 21'h000040,
    S_POPB      = 21'h000080,
    S_INS       = 21'h000100,
    S_INS_CHK   = 21'h000200,
    S_RM        = 21'h000400,
    S_RM_CHK    = 21'h000800,
    S_SRT_START = 21'h001000,
    S_SRT_LD    = 21'h002000,
    S_SRT_RD    = 21'h004000,
    S_SRT_CMP   = 21'h008000,
    S_SRT_END   = 21'h010000,
    S_LS_RD     = 21'h020000,
    S_LS_OUT    = 21'h040000,
    S_DONE      = 21'h080000,
    S_WAIT      = 21'h100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.req)
          REQ_PUSH_FRONT, REQ_INSERT: begin
            if (sts.occ_full) begin
              cmd.res_en     = 1'b1;
              cmd.res_status = ST_FULL;
              cmd.res_last   = 1'b1;
              state_nxt      = S_WAIT;
            end else if (sts.req == REQ_PUSH_FRONT) begin
              // gap opens at the front, idx is still zero here
              cmd.pos_op = P_IDX;
              cmd.idx_op = I_OCC;
              state_nxt  = S_UP;
            end else begin
              state_nxt = S_INS;
            end
          end
          REQ_PUSH_BACK: begin
            if (sts.occ_full) begin
              cmd.res_en     = 1'b1;
              cmd.res_status = ST_FULL;
              cmd.res_last   = 1'b1;
              state_nxt      = S_WAIT;
            end else begin
              cmd.wr        = 1'b1;
              cmd.addr_sel  = A_OCC;
              cmd.wdata_sel = W_OPND;
              cmd.occ_op    = O_INC;
              state_nxt     = S_DONE;
            end
          end
          REQ_POP_FRONT, REQ_POP_BACK, REQ_SORT, REQ_REMOVE, REQ_LIST: begin
            if (sts.occ_zero) begin
              cmd.res_en     = 1'b1;
              cmd.res_status = ST_EMPTY;
              cmd.res_last   = 1'b1;
              state_nxt      = S_WAIT;
            end else if (sts.req == REQ_POP_FRONT) begin
              cmd.rd       = 1'b1;
              cmd.addr_sel = A_IDX;
              state_nxt    = S_POPF;
            end else if (sts.req == REQ_POP_BACK) begin
              cmd.rd       = 1'b1;
              cmd.addr_sel = A_OCC_M1;
              state_nxt    = S_POPB;
            end else if (sts.req == REQ_SORT) begin
              if (sts.occ_one) begin
                state_nxt = S_DONE;
              end else begin
                cmd.pos_op = P_OCC_M1;
                state_nxt  = S_SRT_START;
              end
            end else if (sts.req == REQ_REMOVE) begin
              state_nxt = S_RM;
            end else begin
              state_nxt = S_LS_RD;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      // shift entries up until the gap reaches pos, then drop the operand in
      S_UP: begin
        if (sts.idx_eq_pos) begin
          cmd.wr        = 1'b1;
          cmd.addr_sel  = A_POS;
          cmd.wdata_sel = W_OPND;
          cmd.occ_op    = O_INC;
          state_nxt     = S_DONE;
        end else begin
          cmd.rd       = 1'b1;
          cmd.addr_sel = A_IDX_M1;
          state_nxt    = S_UP_WR;
        end
      end
      S_UP_WR: begin
        cmd.wr        = 1'b1;
        cmd.addr_sel  = A_IDX;
        cmd.wdata_sel = W_RDATA;
        cmd.idx_op    = I_DEC;
        state_nxt     = S_UP;
      end
      // close the gap at idx by moving the tail down one place
      S_DN: begin
        if (sts.idx_p1_eq_occ) begin
          cmd.occ_op = O_DEC;
          state_nxt  = S_DONE;
        end else begin
          cmd.rd       = 1'b1;
          cmd.addr_sel = A_IDX_P1;
          state_nxt    = S_DN_WR;
        end
      end
      S_DN_WR: begin
        cmd.wr        = 1'b1;
        cmd.addr_sel  = A_IDX;
        cmd.wdata_sel = W_RDATA;
        cmd.idx_op    = I_INC;
        state_nxt     = S_DN;
      end
      S_POPF: begin
        cmd.val_capture = 1'b1;
        state_nxt       = S_DN;
      end
      S_POPB: begin
        cmd.val_capture = 1'b1;
        cmd.occ_op      = O_DEC;
        state_nxt       = S_DONE;
      end
      // find the first entry greater than the operand
      S_INS: begin
        if (sts.idx_eq_occ) begin
          cmd.pos_op = P_IDX;
          cmd.idx_op = I_OCC;
          state_nxt  = S_UP;
        end else begin
          cmd.rd       = 1'b1;
          cmd.addr_sel = A_IDX;
          state_nxt    = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        if (sts.lt_opnd) begin
          cmd.pos_op = P_IDX;
          cmd.idx_op = I_OCC;
          state_nxt  = S_UP;
        end else begin
          cmd.idx_op = I_INC;
          state_nxt  = S_INS;
        end
      end
      S_RM: begin
        if (sts.idx_eq_occ) begin
          cmd.res_en     = 1'b1;
          cmd.res_status = ST_NOT_FOUND;
          cmd.res_last   = 1'b1;
          state_nxt      = S_WAIT;
        end else begin
          cmd.rd       = 1'b1;
          cmd.addr_sel = A_IDX;
          state_nxt    = S_RM_CHK;
        end
      end
      S_RM_CHK: begin
        if (sts.eq_opnd) begin
          state_nxt = S_DN;
        end else begin
          cmd.idx_op = I_INC;
          state_nxt  = S_RM;
        end
      end
      // bubble pass: carry the largest value seen toward pos
      S_SRT_START: begin
        cmd.rd       = 1'b1;
        cmd.addr_sel = A_IDX;
        cmd.swap_clr = 1'b1;
        state_nxt    = S_SRT_LD;
      end
      S_SRT_LD: begin
        cmd.carry_capture = 1'b1;
        cmd.idx_op        = I_INC;
        state_nxt         = S_SRT_RD;
      end
      S_SRT_RD: begin
        cmd.rd       = 1'b1;
        cmd.addr_sel = A_IDX;
        state_nxt    = S_SRT_CMP;
      end
      S_SRT_CMP: begin
        cmd.wr       = 1'b1;
        cmd.addr_sel = A_IDX_M1;
        if (sts.lt_carry) begin
          cmd.wdata_sel = W_RDATA;
          cmd.swap_set  = 1'b1;
        end else begin
          cmd.wdata_sel     = W_CARRY;
          cmd.carry_capture = 1'b1;
        end
        if (sts.idx_eq_pos) begin
          state_nxt = S_SRT_END;
        end else begin
          cmd.idx_op = I_INC;
          state_nxt  = S_SRT_RD;
        end
      end
      S_SRT_END: begin
        cmd.wr        = 1'b1;
        cmd.addr_sel  = A_POS;
        cmd.wdata_sel = W_CARRY;
        if (!sts.swap || sts.pos_one) begin
          state_nxt = S_DONE;
        end else begin
          cmd.pos_op = P_DEC;
          cmd.idx_op = I_ZERO;
          state_nxt  = S_SRT_START;
        end
      end
      S_LS_RD: begin
        cmd.rd       = 1'b1;
        cmd.addr_sel = A_IDX;
        state_nxt    = S_LS_OUT;
      end
      S_LS_OUT: begin
        cmd.res_en     = 1'b1;
        cmd.res_status = ST_OK;
        cmd.res_last   = sts.idx_last;
        cmd.res_rdata  = 1'b1;
        state_nxt      = S_WAIT;
      end
      S_DONE: begin
        cmd.res_en     = 1'b1;
        cmd.res_status = ST_OK;
        cmd.res_last   = 1'b1;
        state_nxt      = S_WAIT;
      end
      S_WAIT: begin
        if (sts.out_fire) begin
          if (sts.out_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_op = I_INC;
            state_nxt  = S_LS_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/bounded_sorted_list_engine.sv =====
// bounded_sorted_list_engine: ordered list of signed values with deque, sort and search requests
// top level; depends on bsle_pkg, bsle_in_if, bsle_out_if, bsle_ctrl and bsle_datapath
`timescale 1ns / 1ps

// usage:
//   in_req takes one request item (req_type, operand_value) with valid/ready.
//   out_res returns result items (entry_value, status, entry_count, last_of_run).
//   every request gives one result, except list on a non-empty list, which gives one per entry
//   (at most MAX_RESULTS) front to back, with last_of_run on the final one.
//   the list lives in a single-port entry memory with registered read; all
//   work walks it one entry at a time:
//     full or empty errors are answered on dispatch; push back and pop back touch
//       only the end entry
//     push front, insert, pop front, remove: walk or move entries one by one
//     sort: bubble passes, up to DEPTH-1 of them, stopping after a pass with no swap
//     list: one entry read per result
//   one request is worked on at a time; in_req.ready is high only between
//   requests. a result sits in the output register until taken, and the
//   engine waits there while out_res.ready is low.
//   reset (rst_n low, synchronous) empties the list; no clearing pass runs.

module bounded_sorted_list_engine import bsle_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  bsle_in_if.sink    in_req,
  bsle_out_if.source out_res
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;

  assign in_req.ready = in_ready;

  bsle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bsle_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_req_type      (in_req.req_type),
    .in_operand_value (in_req.operand_value),
    .sts              (sts),
    .out_res          (out_res)
  );

endmodule

// ===== test/bounded_sorted_list_engine_test.sv =====
// bounded_sorted_list_engine_test: self-checking bench for the sorted list engine
// drives requests through bsle_in_if, checks results from bsle_out_if against a local list model
// depends on bsle_pkg, bsle_in_if, bsle_out_if and bounded_sorted_list_engine
`timescale 1ns / 1ps

module bounded_sorted_list_engine_test;
  import bsle_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int END_LATENCY    = 64;
  localparam int RANDOM_CHUNK   = 55;

  typedef logic signed [DATA_W-1:0] value_t;

  typedef struct packed {
    value_t              entry_value;
    status_t             status;
    logic [COUNT_W-1:0]  entry_count;
    logic                last_of_run;
  } list_result_t;

  logic clk;
  logic rst_n;

  bsle_in_if  in_ch ();
  bsle_out_if out_ch ();

  bounded_sorted_list_engine i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_ch),
    .out_res (out_ch)
  );

  value_t       model_entries[$];
  list_result_t pending_results[$];
  int           mismatches = 0;
  int           idle_cycles = 0;
  bit           in_busy = 0;
  bit           steady_flow = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- list model

  function automatic void note_result(value_t v, status_t st, logic last);
    list_result_t r;
    r.entry_value = v;
    r.status      = st;
    r.entry_count = COUNT_W'(model_entries.size());
    r.last_of_run = last;
    pending_results.push_back(r);
  endfunction

  function automatic void apply_request(req_code_t req, value_t opnd);
    value_t  popped;
    value_t  key;
    status_t st;
    int      pos;
    int      j;
    int      n;
    popped = '0;
    st     = ST_OK;
    case (req)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (model_entries.size() >= DEPTH) st = ST_FULL;
        else if (req == REQ_PUSH_FRONT) model_entries.push_front(opnd);
        else model_entries.push_back(opnd);
      end
      REQ_POP_FRONT: begin
        if (model_entries.size() == 0) st = ST_EMPTY;
        else popped = model_entries.pop_front();
      end
      REQ_POP_BACK: begin
        if (model_entries.size() == 0) st = ST_EMPTY;
        else popped = model_entries.pop_back();
      end
      REQ_SORT: begin
        if (model_entries.size() == 0) st = ST_EMPTY;
        else begin
          for (int i = 1; i < model_entries.size(); i++) begin
            key = model_entries[i];
            j = i;
            while (j > 0 && key < model_entries[j-1]) begin
              model_entries[j] = model_entries[j-1];
              j--;
            end
            model_entries[j] = key;
          end
        end
      end
      REQ_INSERT: begin
        if (model_entries.size() >= DEPTH) st = ST_FULL;
        else begin
          // goes after equal values, before the first greater one
          pos = 0;
          while (pos < model_entries.size() && !(opnd < model_entries[pos])) pos++;
          model_entries.insert(pos, opnd);
        end
      end
      REQ_REMOVE: begin
        if (model_entries.size() == 0) st = ST_EMPTY;
        else begin
          pos = 0;
          while (pos < model_entries.size() && model_entries[pos] !== opnd) pos++;
          if (pos == model_entries.size()) st = ST_NOT_FOUND;
          else model_entries.delete(pos);
        end
      end
      default: begin
        n = model_entries.size();
        if (n > MAX_RESULTS) n = MAX_RESULTS;
        if (n == 0) note_result('0, ST_EMPTY, 1'b1);
        for (int k = 0; k < n; k++) note_result(model_entries[k], ST_OK, k + 1 == n);
        return;
      end
    endcase
    note_result(popped, st, 1'b1);
  endfunction

  // ---------------------------------------------------------------- request side

  function automatic int pick_gap();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic lower_input();
    if (in_busy) begin
      in_ch.valid <= 1'b0;
      in_busy = 0;
    end
  endtask

  task automatic send_req(req_code_t req, value_t opnd);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      lower_input();
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.req_type      <= req;
    in_ch.operand_value <= opnd;
    in_busy = 1;
    do @(posedge clk); while (!in_ch.ready);
    apply_request(req, opnd);
  endtask

  task automatic wait_results_done();
    lower_input();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic value_t pick_operand();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30 && model_entries.size() != 0)
      return model_entries[$urandom_range(0, model_entries.size() - 1)];
    if (r < 60) return value_t'($urandom_range(0, 8)) - 4;
    if (r < 75) begin
      case ($urandom_range(0, 4))
        0: return {1'b1, {(DATA_W-1){1'b0}}};
        1: return {1'b0, {(DATA_W-1){1'b1}}};
        2: return '0;
        3: return '1;
        default: return 1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic req_code_t pick_request(int target);
    int occ;
    int r;
    occ = model_entries.size();
    r = $urandom_range(0, 99);
    if (r < 8) return REQ_LIST;
    if (r < 14) return REQ_SORT;
    if (occ < target) begin
      if (r < 40) return REQ_INSERT;
      if (r < 60) return REQ_PUSH_BACK;
      if (r < 80) return REQ_PUSH_FRONT;
      if (r < 87) return REQ_REMOVE;
      if (r < 93) return REQ_POP_FRONT;
      return REQ_POP_BACK;
    end
    if (occ > target) begin
      if (r < 40) return REQ_REMOVE;
      if (r < 60) return REQ_POP_FRONT;
      if (r < 80) return REQ_POP_BACK;
      if (r < 87) return REQ_INSERT;
      if (r < 93) return REQ_PUSH_FRONT;
      return REQ_PUSH_BACK;
    end
    return req_code_t'($urandom_range(0, 6));
  endfunction

  // ---------------------------------------------------------------- result side

  initial begin
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (steady_flow) begin
        out_ch.ready <= 1'b1;
        stall = 0;
      end else if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else if ($urandom_range(0, 99) < 70) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        stall = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: value %0d status %0d count %0d last %0b",
                   out_ch.entry_value, out_ch.status, out_ch.entry_count, out_ch.last_of_run);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.entry_value !== want.entry_value || out_ch.status !== want.status ||
            out_ch.entry_count !== want.entry_count || out_ch.last_of_run !== want.last_of_run)
        begin
          if (mismatches < 10)
            $display({"result mismatch: value %0d/%0d status %0d/%0d count %0d/%0d ",
                      "last %0b/%0b (exp/act)"},
                     want.entry_value, out_ch.entry_value, want.status, out_ch.status,
                     want.entry_count, out_ch.entry_count, want.last_of_run, out_ch.last_of_run);
          mismatches++;
        end
      end
    end
  end

  // no item moving on either side for too long means the engine is stuck
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("** bounded_sorted_list_engine: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_empty_list();
    send_req(REQ_LIST, '0);
    send_req(REQ_POP_FRONT, '0);
    send_req(REQ_POP_BACK, '1);
    send_req(REQ_SORT, '0);
    send_req(REQ_REMOVE, '0);
  endtask

  task automatic test_single_entry();
    send_req(REQ_PUSH_BACK, 7);
    send_req(REQ_SORT, '0);
    send_req(REQ_LIST, '0);
    send_req(REQ_REMOVE, 8);
    send_req(REQ_REMOVE, 7);
  endtask

  task automatic test_extreme_values();
    send_req(REQ_PUSH_FRONT, {1'b0, {(DATA_W-1){1'b1}}});
    send_req(REQ_PUSH_BACK, {1'b1, {(DATA_W-1){1'b0}}});
    send_req(REQ_INSERT, '0);
    send_req(REQ_INSERT, '0);
    send_req(REQ_INSERT, '1);
    send_req(REQ_LIST, '0);
    send_req(REQ_SORT, '0);
    send_req(REQ_LIST, '0);
    send_req(REQ_POP_FRONT, '0);
    send_req(REQ_POP_BACK, '0);
  endtask

  task automatic test_full_list();
    value_t v;
    while (model_entries.size() < DEPTH) begin
      v = value_t'($urandom_range(0, 8)) - 4;
      case ($urandom_range(0, 2))
        0: send_req(REQ_PUSH_FRONT, v);
        1: send_req(REQ_PUSH_BACK, v);
        default: send_req(REQ_INSERT, v);
      endcase
    end
    send_req(REQ_PUSH_FRONT, $urandom);
    send_req(REQ_PUSH_BACK, $urandom);
    send_req(REQ_INSERT, $urandom);
    send_req(REQ_LIST, '0);
    send_req(REQ_SORT, '0);
    send_req(REQ_LIST, '0);
    send_req(REQ_REMOVE, 32'h1234_5678);
    while (model_entries.size() > 0) begin
      case ($urandom_range(0, 2))
        0: send_req(REQ_POP_FRONT, $urandom);
        1: send_req(REQ_POP_BACK, $urandom);
        default: send_req(REQ_REMOVE,
                          model_entries[$urandom_range(0, model_entries.size() - 1)]);
      endcase
    end
    send_req(REQ_POP_FRONT, '0);
  endtask

  task automatic test_random_mix(int count);
    int        target;
    req_code_t req;
    value_t    v;
    target = $urandom_range(0, DEPTH);
    for (int n = 0; n < count; n++) begin
      if (n % 20 == 0) begin
        case ($urandom_range(0, 3))
          0: target = 0;
          1: target = DEPTH;
          default: target = $urandom_range(0, DEPTH);
        endcase
      end
      req = pick_request(target);
      v = pick_operand();
      // removes mostly hit a stored value
      if (req == REQ_REMOVE && model_entries.size() != 0 && $urandom_range(0, 99) < 60)
        v = model_entries[$urandom_range(0, model_entries.size() - 1)];
      send_req(req, v);
    end
  endtask

  initial begin
    in_ch.valid         <= 1'b0;
    in_ch.req_type      <= REQ_PUSH_FRONT;
    in_ch.operand_value <= '0;
    rst_n               <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_single_entry();
    test_extreme_values();
    test_full_list();
    test_random_mix(RANDOM_CHUNK);
    steady_flow = 1;
    test_random_mix(RANDOM_CHUNK);
    steady_flow = 0;
    test_random_mix(RANDOM_CHUNK);
    // hold the sender until the engine has caught up
    wait_results_done();
    test_random_mix(RANDOM_CHUNK);

    wait_results_done();
    repeat (END_LATENCY) @(posedge clk);
    if (pending_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("** bounded_sorted_list_engine: PASSED **");
    end else begin
      $display("** bounded_sorted_list_engine: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/bsle_pkg.sv
src/bsle_in_if.sv
src/bsle_out_if.sv
src/bsle_datapath.sv
src/bsle_ctrl.sv
src/bounded_sorted_list_engine.sv
test/bounded_sorted_list_engine_test.sv
